@@ sv/htip_pkg.sv @@
// ----------------------------------------------------------------------------
// htip_pkg - shared definitions for the hash table insert/probe block
// Field widths, the Fibonacci hashing multiplier and result status codes.
// ----------------------------------------------------------------------------
package htip_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int KEY_W          = 63;
    localparam int SLOT_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int PROD_W         = 32;

    // Golden-ratio multiplier; only its low word reaches the slot bits.
    localparam logic [63:0]       FIB_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [PROD_W-1:0] FIB_LO   = FIB_MULT[PROD_W-1:0];

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW   = 2'd0,
        ST_FOUND = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

endpackage

@@ sv/htip_ram.sv @@
// ----------------------------------------------------------------------------
// htip_ram - generic single-port synchronous RAM
// One access per cycle; read data is registered.
// ----------------------------------------------------------------------------
module htip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/hash_table_insert_probe.sv @@
// ----------------------------------------------------------------------------
// hash_table_insert_probe - open-addressed key table with linear probing
// Finds a key or inserts it; Fibonacci hashing picks the home slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present i_key with start high; the request is taken at
//   a rising edge where start is high and busy is low. Key zero is reserved.
//   Result channel: o_valid pulses for one cycle with o_slot_index and
//   o_status (new, found, full, zero key). The receiver cannot stall; the
//   result must be taken in that cycle.
//   Sequence: a zero key, or a request met while the table sits at its load
//   limit (fill+1 >= TABLE_SIZE/2), is answered in the cycle after it is
//   taken. Otherwise the accepting edge captures the key's low word times
//   the golden ratio constant, the HASH state sets the home slot, then each
//   probe passes through PROBE (key store read) and CMP (compare) on the
//   single key store port. For a probed key busy stays high until the result
//   is shown, so one request is in flight at a time.
//   Reset: i_rst_n (synchronous, active low) zeroes the fill count and then
//   sweeps the key store, writing one empty slot per cycle; busy stays high
//   until the sweep has written the last slot.
// ----------------------------------------------------------------------------
module hash_table_insert_probe #(
    parameter int TABLE_SIZE = htip_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [htip_pkg::KEY_W-1:0]    i_key,
    output logic                          busy,
    output logic                          o_valid,
    output logic [htip_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [htip_pkg::STATUS_W-1:0] o_status
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int KEY_W = htip_pkg::KEY_W;
    localparam int SLOT_W = htip_pkg::SLOT_W;
    localparam logic [IDX_W:0] HALF = (IDX_W + 1)'(TABLE_SIZE / 2);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CMP
    } t_state;

    t_state                     r_state, n_state;
    logic [KEY_W-1:0]           r_key, n_key;
    logic [htip_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [IDX_W-1:0]           r_probes, n_probes;
    logic [IDX_W-1:0]           r_count, n_count;
    logic                       r_valid, n_valid;
    logic [IDX_W-1:0]           r_slot, n_slot;
    htip_pkg::t_status          r_status, n_status;

    logic                       ram_en, ram_we;
    logic [KEY_W-1:0]           ram_wdata, ram_rdata;
    logic                       at_limit;
    logic [SLOT_W+IDX_W-1:0]    slot_wide;

    htip_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_keys (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (r_idx),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign at_limit = ({1'b0, r_count} + (IDX_W + 1)'(1)) >= HALF;

    // Key store port: sweep during clear, read while probing, write on insert.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = r_key;
        unique case (r_state)
            S_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_PROBE: begin
                ram_en = 1'b1;
            end
            S_CMP: begin
                ram_en = (ram_rdata == '0);
                ram_we = (ram_rdata == '0);
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_prod   = r_prod;
        n_idx    = r_idx;
        n_probes = r_probes;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_slot   = r_slot;
        n_status = r_status;
        unique case (r_state)
            S_CLEAR: begin
                // Advance the sweep; the last slot hands over to idle.
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_key = i_key;
                    if (i_key == '0) begin
                        n_valid  = 1'b1;
                        n_slot   = '0;
                        n_status = htip_pkg::ST_ZERO;
                    end else if (at_limit) begin
                        n_valid  = 1'b1;
                        n_slot   = '0;
                        n_status = htip_pkg::ST_FULL;
                    end else begin
                        // Low product word holds every bit the home slot uses.
                        n_prod  = htip_pkg::PROD_W'(i_key[htip_pkg::PROD_W-1:0]
                                                    * htip_pkg::FIB_LO);
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_idx    = r_prod[2*IDX_W-1:IDX_W];
                n_probes = '0;
                n_state  = S_PROBE;
            end
            S_PROBE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (ram_rdata == '0) begin
                    n_count  = r_count + IDX_W'(1);
                    n_valid  = 1'b1;
                    n_slot   = r_idx;
                    n_status = htip_pkg::ST_NEW;
                    n_state  = S_IDLE;
                end else if (ram_rdata == r_key) begin
                    n_valid  = 1'b1;
                    n_slot   = r_idx;
                    n_status = htip_pkg::ST_FOUND;
                    n_state  = S_IDLE;
                end else if (r_probes == '1) begin
                    // Every slot visited: report full.
                    n_valid  = 1'b1;
                    n_slot   = '0;
                    n_status = htip_pkg::ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_idx    = r_idx + IDX_W'(1);
                    n_probes = r_probes + IDX_W'(1);
                    n_state  = S_PROBE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_key    <= n_key;
        r_prod   <= n_prod;
        r_probes <= n_probes;
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    assign slot_wide    = {{SLOT_W{1'b0}}, r_slot};
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_slot_index = slot_wide[SLOT_W-1:0];
    assign o_status     = r_status;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - self-checking bench for hash_table_insert_probe
// Drives keys through the start/busy command port and predicts every slot
// and status with an independent linear probing table model. The sequence
// runs directed corner keys, clustered and repeated random keys with random
// idle gaps, then fills the table to its load limit and probes it there.
// ----------------------------------------------------------------------------
module testbench;

    localparam int KEY_W      = htip_pkg::KEY_W;
    localparam int SLOT_W     = htip_pkg::SLOT_W;
    localparam int STATUS_W   = htip_pkg::STATUS_W;
    localparam int TBL_SIZE   = htip_pkg::TABLE_SIZE_DEF;
    localparam int TBL_LOG2   = $clog2(TBL_SIZE);
    localparam int N_RANDOM   = 750;
    // Worst case: reset sweep of the key store, or a probe run across
    // half the table, plus the sender's longest gap.
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        htip_pkg::t_status status;
    } t_slot_answer;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the key table, works out the answer
    // for every accepted request and matches results against them in order.
    // ------------------------------------------------------------------------
    class slot_tracker;
        logic [KEY_W-1:0] slot_keys [TBL_SIZE];
        int unsigned      fill;
        int unsigned      errors;
        t_slot_answer     pending_answers [$];
        logic [KEY_W-1:0] stored_keys [$];

        function new();
            foreach (slot_keys[i]) slot_keys[i] = '0;
            fill   = 0;
            errors = 0;
        endfunction

        // Fibonacci hash: low 64 bits of the product, drop log2 bits, mask.
        function int unsigned home_slot(logic [KEY_W-1:0] k);
            logic [63:0] prod;
            prod = {1'b0, k} * htip_pkg::FIB_MULT;
            return int'((prod >> TBL_LOG2) & 64'(TBL_SIZE - 1));
        endfunction

        function void note_request(logic [KEY_W-1:0] k);
            t_slot_answer ans;
            int unsigned  home;
            int unsigned  ix;
            bit           done;
            ans.slot   = '0;
            ans.status = htip_pkg::ST_FULL;
            if (k == '0) begin
                // Zero key is rejected ahead of the load check.
                ans.status = htip_pkg::ST_ZERO;
            end else if (fill + 1 < TBL_SIZE / 2) begin
                home = home_slot(k);
                done = 1'b0;
                for (int i = 0; i < TBL_SIZE && !done; i++) begin
                    ix = (home + i) % TBL_SIZE;
                    if (slot_keys[ix] == '0) begin
                        slot_keys[ix] = k;
                        fill++;
                        stored_keys.push_back(k);
                        ans.slot   = SLOT_W'(ix);
                        ans.status = htip_pkg::ST_NEW;
                        done       = 1'b1;
                    end else if (slot_keys[ix] == k) begin
                        ans.slot   = SLOT_W'(ix);
                        ans.status = htip_pkg::ST_FOUND;
                        done       = 1'b1;
                    end
                end
            end
            // At the load limit even a stored key is answered as full.
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status);
            t_slot_answer ans;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: slot_index %0d status %0d", slot, status);
                errors++;
            end else begin
                ans = pending_answers.pop_front();
                if (status !== ans.status) begin
                    $error("status: expected %0d, actual %0d", ans.status, status);
                    errors++;
                end
                if (slot !== ans.slot) begin
                    $error("slot_index: expected %0d, actual %0d", ans.slot, slot);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [KEY_W-1:0]   i_key   = '0;
    logic               busy;
    logic               o_valid;
    logic [SLOT_W-1:0]  o_slot_index;
    logic [STATUS_W-1:0] o_status;

    slot_tracker        sb;
    int unsigned        idle_cycles = 0;
    bit                 burst_mode  = 1'b0;
    logic [15:0]        cluster_low [4];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hash_table_insert_probe #(
        .TABLE_SIZE (TBL_SIZE)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_key        (i_key),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_slot_index (o_slot_index),
        .o_status     (o_status)
    );

    // Results cannot be held off: take each one at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_slot_index, o_status);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("hash_table_insert_probe test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    // Same low 16 bits give the same home slot, so these keys pile up
    // into long probe runs.
    function automatic logic [KEY_W-1:0] clustered_key();
        logic [KEY_W-1:0] r;
        r = rand_key();
        return {r[KEY_W-1:16], cluster_low[$urandom_range(0, 3)]};
    endfunction

    function automatic logic [KEY_W-1:0] stored_or_rand_key();
        if (sb.stored_keys.size() == 0) return rand_key();
        return sb.stored_keys[$urandom_range(0, sb.stored_keys.size() - 1)];
    endfunction

    // Idle for a drawn number of cycles, then hold the request until taken.
    task automatic send_request(input logic [KEY_W-1:0] k);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_key <= rand_key();
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_key <= k;
        do @(posedge i_clk); while (busy);
        sb.note_request(k);
    endtask

    // Drop start and hold off until every answer has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] wrap_keys [4];
        logic [KEY_W-1:0] k;
        logic [15:0]      v;
        int unsigned      pick;

        sb = new();

        // Find a low word whose home slot is the last one, so that probing
        // has to wrap round to slot 0.
        v = 16'($urandom_range(0, 65535));
        for (int n = 0; n < 65536; n++) begin
            if (sb.home_slot({{(KEY_W-16){1'b0}}, v}) != TBL_SIZE - 1) v = v + 16'd1;
        end
        cluster_low[0] = v;
        for (int n = 1; n < 4; n++) cluster_low[n] = 16'($urandom_range(0, 65535));
        foreach (wrap_keys[n]) begin
            k            = rand_key();
            wrap_keys[n] = {k[KEY_W-1:16], cluster_low[0]};
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero key, extreme keys, repeats and a wrapping cluster.
        send_request('0);
        send_request({KEY_W{1'b1}});
        send_request({{(KEY_W-1){1'b0}}, 1'b1});
        send_request({KEY_W{1'b1}});
        send_request({{(KEY_W-1){1'b0}}, 1'b1});
        send_request({1'b1, {(KEY_W-1){1'b0}}});
        foreach (wrap_keys[n]) send_request(wrap_keys[n]);
        for (int n = 3; n >= 0; n--) send_request(wrap_keys[n]);
        send_request('0);
        send_request(KEY_W'({(KEY_W+1)/2{2'b10}}));
        send_request(KEY_W'({(KEY_W+1)/2{2'b01}}));
        wait_drained();

        // Random: mostly repeats of stored keys, a trickle of new ones so
        // the table reaches its load limit late in the run.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (n % 150 == 149) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 6)       k = '0;
            else if (pick < 13) k = rand_key();
            else if (pick < 20) k = clustered_key();
            else                k = stored_or_rand_key();
            send_request(k);
        end

        // Fill to the load limit, then probe the full table.
        burst_mode = 1'b0;
        while (sb.fill + 1 < TBL_SIZE / 2) begin
            send_request(($urandom_range(0, 1) == 0) ? clustered_key() : rand_key());
        end
        for (int n = 0; n < 12; n++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)      k = '0;
            else if (pick == 1) k = rand_key();
            else                k = stored_or_rand_key();
            send_request(k);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending_answers.size() != 0) begin
            $error("%0d answers never arrived", sb.pending_answers.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("hash_table_insert_probe test passed");
        end else begin
            $display("hash_table_insert_probe test failed");
        end
        $finish;
    end

endmodule
